/* rtl/uglr_pkg.sv */
// shared types and constants of the uniform grid linear resampler
package uglr_pkg;

  // channel and field geometry
  localparam int NUM_CH   = 6;
  localparam int CH_W     = 3;
  localparam int DATA_W   = 32;
  localparam int TDATA_W  = DATA_W * (NUM_CH + 1);
  localparam int STEP_W   = 20;
  localparam int GRID_W   = 33;
  localparam logic [CH_W-1:0]   LAST_CH    = CH_W'(NUM_CH - 1);
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd10000;

  // shared divider geometry
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_CNT_W  = 7;

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_GRID_START = 9'b000000010,
    S_GRID_WAIT  = 9'b000000100,
    S_CH_DIFF    = 9'b000001000,
    S_CH_MUL     = 9'b000010000,
    S_CH_START   = 9'b000100000,
    S_CH_WAIT    = 9'b001000000,
    S_PT_UPD     = 9'b010000000,
    S_PT_OUT     = 9'b100000000
  } state_e;

  // divider request and response
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

endpackage

/* rtl/uglr_divider.sv */
// radix-2 restoring unsigned divider, one quotient bit per cycle
module uglr_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  uglr_pkg::div_req_t  req_i,
  output uglr_pkg::div_rsp_t  rsp_o
);
  import uglr_pkg::*;

  logic                  busy_q, done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q, dvs_q;

  logic [DIVISOR_W:0]    shifted;
  logic                  fits;
  logic [DIVISOR_W:0]    reduced;

  // one restoring step
  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    fits    = shifted >= {1'b0, dvs_q};
    reduced = shifted - {1'b0, dvs_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? reduced[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* rtl/uniform_grid_linear_resampler_core.sv */
// top level: resamples six-channel pose samples onto a uniform time grid
// a new sample is accepted only in the idle state, after every point of the previous run
// per sample: at most 13 divisions (one grid, two per channel) plus 64 points
// every division runs on the shared radix-2 divider; each point takes six channel
// update steps and one output state, plus any output stall
// reset: asynchronous active low; clears the track state and sets grid_step to 10000
module uniform_grid_linear_resampler_core #(
  parameter int MAX_RUN    = 64,
  parameter int VALUE_BITS = 32,
  parameter int TIME_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config
  input  logic                          cfg_we_i,
  input  logic [uglr_pkg::STEP_W-1:0]   cfg_wdata_i,
  // input samples
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sample_time, pos_x, pos_y, pos_z, angle_roll, angle_pitch, angle_yaw
  input  logic [uglr_pkg::TDATA_W-1:0]  s_axis_tdata,
  // restart
  input  logic                          s_axis_tuser,
  // output grid points
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // grid_time, out_x, out_y, out_z, out_roll, out_pitch, out_yaw
  output logic [uglr_pkg::TDATA_W-1:0]  m_axis_tdata,
  // run_last
  output logic                          m_axis_tlast,
  // gap_overflow
  output logic                          m_axis_tuser
);
  import uglr_pkg::*;

  localparam int PW = $clog2(MAX_RUN + 1);
  localparam logic [DATA_W-1:0] TIME_MASK = DATA_W'((64'd1 << TIME_BITS) - 64'd1);

  function automatic logic [DATA_W-1:0] sext_value(input logic [DATA_W-1:0] raw);
    return DATA_W'(signed'(raw[VALUE_BITS-1:0]));
  endfunction

  state_e               state_q;
  logic [CH_W-1:0]      ch_q;
  logic                 phase_q;
  logic [PW-1:0]        points_q;
  logic                 ovf_q;
  logic [STEP_W-1:0]    step_q;
  logic                 have_prev_q;
  logic [DATA_W-1:0]    prev_t_q;
  logic [DATA_W-1:0]    prev_v_q [NUM_CH];
  logic [GRID_W-1:0]    ngt_q;

  logic                 first_q;
  logic [DATA_W-1:0]    cur_t_q;
  logic [DATA_W-1:0]    cur_v_q [NUM_CH];
  logic [GRID_W-1:0]    gt_q, ngt_next_q;
  logic [DATA_W-1:0]    d_q, dt0_q, mag_q;
  logic [DIVIDEND_W-1:0] prod_q;
  logic [DATA_W-1:0]    v0_q    [NUM_CH];
  logic                 neg_q   [NUM_CH];
  logic [DATA_W-1:0]    qacc_q  [NUM_CH];
  logic [DATA_W-1:0]    racc_q  [NUM_CH];
  logic [DATA_W-1:0]    qinc_q  [NUM_CH];
  logic [DATA_W-1:0]    rinc_q  [NUM_CH];
  logic [DATA_W-1:0]    outv_q  [NUM_CH];

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [DATA_W-1:0]    in_time;
  logic [DATA_W-1:0]    in_val [NUM_CH];
  logic                 in_accept, in_first, in_go;
  logic [GRID_W-1:0]    ngt_eff;
  logic [STEP_W-1:0]    step_eff;
  logic                 out_hs;
  logic                 run_ovf;
  logic [PW-1:0]        run_len;
  logic [DATA_W:0]      diff;
  logic [DATA_W-1:0]    mul_op;
  logic [DATA_W:0]      sum_r;
  logic                 wrap;
  logic [DATA_W-1:0]    r_new, q_new, val;

  // input unpacking and sample classification
  always_comb begin
    in_time = s_axis_tdata[DATA_W-1:0] & TIME_MASK;
    for (int i = 0; i < NUM_CH; i++) begin
      in_val[i] = sext_value(s_axis_tdata[DATA_W*(i+1) +: DATA_W]);
    end
    in_accept = s_axis_tvalid & s_axis_tready;
    in_first  = s_axis_tuser | ~have_prev_q;
    ngt_eff   = s_axis_tuser ? '0 : ngt_q;
    in_go     = (in_first | (in_time > prev_t_q)) & (ngt_eff <= {1'b0, in_time});
    step_eff  = (step_q == '0) ? STEP_W'(1) : step_q;
    out_hs    = m_axis_tvalid & m_axis_tready;
  end

  // run length from the grid division
  always_comb begin
    run_ovf = div_rsp.quotient >= DIVIDEND_W'(MAX_RUN);
    run_len = run_ovf ? PW'(MAX_RUN) : (PW'(div_rsp.quotient) + PW'(1));
  end

  // channel difference and multiplier operand
  always_comb begin
    diff   = {cur_v_q[ch_q][DATA_W-1], cur_v_q[ch_q]} -
             {prev_v_q[ch_q][DATA_W-1], prev_v_q[ch_q]};
    mul_op = phase_q ? DATA_W'(step_eff) : dt0_q;
  end

  // per point quotient and remainder stepping
  always_comb begin
    sum_r = {1'b0, racc_q[ch_q]} + {1'b0, rinc_q[ch_q]};
    wrap  = sum_r >= {1'b0, d_q};
    r_new = wrap ? DATA_W'(sum_r - {1'b0, d_q}) : sum_r[DATA_W-1:0];
    q_new = qacc_q[ch_q] + qinc_q[ch_q] + DATA_W'(wrap);
    val   = neg_q[ch_q] ? (v0_q[ch_q] - qacc_q[ch_q]) : (v0_q[ch_q] + qacc_q[ch_q]);
  end

  // shared divider
  always_comb begin
    div_req.start = (state_q == S_GRID_START) || (state_q == S_CH_START);
    if (state_q == S_GRID_START) begin
      div_req.dividend = DIVIDEND_W'(cur_t_q - ngt_q[DATA_W-1:0]);
      div_req.divisor  = DIVISOR_W'(step_eff);
    end else begin
      div_req.dividend = prod_q;
      div_req.divisor  = d_q;
    end
  end

  uglr_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer and track state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      phase_q     <= 1'b0;
      points_q    <= '0;
      ovf_q       <= 1'b0;
      step_q      <= STEP_RESET;
      have_prev_q <= 1'b0;
      prev_t_q    <= '0;
      ngt_q       <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        prev_v_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            ngt_q <= ngt_eff;
            if (in_go) begin
              state_q <= S_GRID_START;
            end else begin
              have_prev_q <= 1'b1;
              prev_t_q    <= in_time;
              prev_v_q    <= in_val;
            end
          end
        end
        S_GRID_START: begin
          state_q <= S_GRID_WAIT;
        end
        S_GRID_WAIT: begin
          if (div_rsp.done) begin
            points_q <= run_len;
            ovf_q    <= run_ovf;
            ch_q     <= '0;
            phase_q  <= 1'b0;
            state_q  <= first_q ? S_PT_UPD : S_CH_DIFF;
          end
        end
        S_CH_DIFF: begin
          state_q <= S_CH_MUL;
        end
        S_CH_MUL: begin
          state_q <= S_CH_START;
        end
        S_CH_START: begin
          state_q <= S_CH_WAIT;
        end
        S_CH_WAIT: begin
          if (div_rsp.done) begin
            if (!phase_q) begin
              phase_q <= 1'b1;
              state_q <= S_CH_MUL;
            end else begin
              phase_q <= 1'b0;
              if (ch_q == LAST_CH) begin
                ch_q    <= '0;
                state_q <= S_PT_UPD;
              end else begin
                ch_q    <= ch_q + CH_W'(1);
                state_q <= S_CH_DIFF;
              end
            end
          end
        end
        S_PT_UPD: begin
          if (ch_q == LAST_CH) begin
            ch_q    <= '0;
            state_q <= S_PT_OUT;
          end else begin
            ch_q <= ch_q + CH_W'(1);
          end
        end
        S_PT_OUT: begin
          if (out_hs) begin
            points_q <= points_q - PW'(1);
            if (points_q == PW'(1)) begin
              have_prev_q <= 1'b1;
              prev_t_q    <= cur_t_q;
              prev_v_q    <= cur_v_q;
              ngt_q       <= ngt_next_q;
              state_q     <= S_IDLE;
            end else begin
              state_q <= S_PT_UPD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cur_t_q <= in_time;
      cur_v_q <= in_val;
      first_q <= in_first;
    end
    unique case (state_q)
      S_GRID_WAIT: begin
        if (div_rsp.done) begin
          gt_q       <= ngt_q;
          ngt_next_q <= {1'b0, cur_t_q} - GRID_W'(div_rsp.remainder) + GRID_W'(step_eff);
          dt0_q      <= ngt_q[DATA_W-1:0] - prev_t_q;
          if (first_q) begin
            d_q <= DATA_W'(1);
            for (int i = 0; i < NUM_CH; i++) begin
              v0_q[i]   <= cur_v_q[i];
              neg_q[i]  <= 1'b0;
              qacc_q[i] <= '0;
              racc_q[i] <= '0;
              qinc_q[i] <= '0;
              rinc_q[i] <= '0;
            end
          end else begin
            d_q <= cur_t_q - prev_t_q;
          end
        end
      end
      S_CH_DIFF: begin
        neg_q[ch_q] <= diff[DATA_W];
        mag_q       <= diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
        v0_q[ch_q]  <= prev_v_q[ch_q];
      end
      S_CH_MUL: begin
        prod_q <= DIVIDEND_W'(mag_q) * DIVIDEND_W'(mul_op);
      end
      S_CH_WAIT: begin
        if (div_rsp.done) begin
          if (!phase_q) begin
            qacc_q[ch_q] <= div_rsp.quotient[DATA_W-1:0];
            racc_q[ch_q] <= div_rsp.remainder;
          end else begin
            qinc_q[ch_q] <= div_rsp.quotient[DATA_W-1:0];
            rinc_q[ch_q] <= div_rsp.remainder;
          end
        end
      end
      S_PT_UPD: begin
        outv_q[ch_q] <= val;
        qacc_q[ch_q] <= q_new;
        racc_q[ch_q] <= r_new;
      end
      S_PT_OUT: begin
        if (out_hs) begin
          gt_q <= gt_q + GRID_W'(step_eff);
        end
      end
      default: begin
      end
    endcase
  end

  // output packing
  always_comb begin
    m_axis_tdata[DATA_W-1:0] = gt_q[DATA_W-1:0];
    for (int i = 0; i < NUM_CH; i++) begin
      m_axis_tdata[DATA_W*(i+1) +: DATA_W] = outv_q[i];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_PT_OUT);
  assign m_axis_tlast  = (points_q == PW'(1));
  assign m_axis_tuser  = ovf_q;

`ifndef ASSERT_OFF
  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == S_GRID_WAIT) || (state_q == S_CH_WAIT)))
    else $error("divider result with no waiting sequencer");

  // no new sample while a division is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_rsp.busy)
    else $error("ready asserted while divider busy");

  // an emitted point always has a nonzero run count behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (points_q != '0))
    else $error("output valid with empty run");

  // the last point of a run returns the block to ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_hs && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready after last point of run");

  // accumulated remainders stay below the gap length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PT_UPD) |-> (racc_q[ch_q] < d_q))
    else $error("interpolation remainder out of range");
`endif

endmodule

/* bench/uniform_grid_linear_resampler_core_test.sv */
// testbench for the uniform grid linear resampler: predicts every grid point and checks the stream
`timescale 1ns / 1ps

module uniform_grid_linear_resampler_core_test;
  import uglr_pkg::*;

  localparam int          RUN_LIMIT    = 64;
  localparam int          SETTLE_CYCLES = 1500;
  localparam longint      TIMEOUT_NS   = 20_000_000;
  localparam int          PHASE_ITEMS  = 64;

  // how the channel values of a generated sample are filled
  typedef enum int {
    FILL_RANDOM,
    FILL_HIGH,
    FILL_LOW,
    FILL_ZERO
  } fill_e;

  typedef struct {
    logic [DATA_W-1:0]        stamp;
    logic signed [DATA_W-1:0] ch [NUM_CH];
    logic                     restart;
  } pose_sample_t;

  typedef struct {
    logic [DATA_W-1:0] stamp;
    logic [DATA_W-1:0] ch [NUM_CH];
    logic              last;
    logic              ovf;
  } grid_point_t;

  // resampling tracker: mirrors the track state and holds the grid points still due
  class pose_grid_tracker;
    logic [STEP_W-1:0] grid_step;
    bit                have_prev;
    longint unsigned   prev_stamp;
    longint            prev_ch [NUM_CH];
    longint unsigned   next_grid;
    grid_point_t       pending_points [$];
    int unsigned       mismatches;

    function new();
      grid_step  = STEP_RESET;
      have_prev  = 1'b0;
      prev_stamp = 0;
      next_grid  = 0;
      mismatches = 0;
      foreach (prev_ch[c]) prev_ch[c] = 0;
    endfunction

    function int unsigned pending();
      return pending_points.size();
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // work out the grid points that one accepted sample releases
    function void note_sample(pose_sample_t s);
      longint unsigned t1, step, count, run, gt, mag, q, k;
      longint          v1 [NUM_CH];
      longint          diff, v;
      bit              first, ovf;
      grid_point_t     p;
      int              c;
      t1   = s.stamp;
      step = (grid_step == '0) ? 1 : grid_step;
      for (c = 0; c < NUM_CH; c++) v1[c] = s.ch[c];
      if (s.restart) begin
        have_prev = 1'b0;
        next_grid = 0;
      end
      first = !have_prev;
      count = 0;
      if ((first || t1 > prev_stamp) && next_grid <= t1)
        count = (t1 - next_grid) / step + 1;
      ovf = (count > RUN_LIMIT);
      run = ovf ? RUN_LIMIT : count;
      for (k = 0; k < run; k++) begin
        gt      = next_grid + k * step;
        p.stamp = gt[DATA_W-1:0];
        for (c = 0; c < NUM_CH; c++) begin
          if (first) begin
            v = v1[c];
          end else begin
            // magnitude of the step scaled by elapsed time, truncated toward zero
            diff = v1[c] - prev_ch[c];
            mag  = (diff < 0) ? -diff : diff;
            q    = mag * (gt - prev_stamp) / (t1 - prev_stamp);
            v    = (diff < 0) ? prev_ch[c] - longint'(q) : prev_ch[c] + longint'(q);
          end
          p.ch[c] = v[DATA_W-1:0];
        end
        p.last = (k + 1 == run);
        p.ovf  = ovf;
        pending_points.push_back(p);
      end
      next_grid  += count * step;
      have_prev  = 1'b1;
      prev_stamp = t1;
      prev_ch    = v1;
    endfunction

    // compare one emitted grid point against the oldest one due
    task check_point(grid_point_t got);
      grid_point_t want;
      int          c;
      if (pending_points.size() == 0) begin
        report($sformatf("grid point at %0d with no sample waiting for it", got.stamp));
        return;
      end
      want = pending_points.pop_front();
      if (got.stamp !== want.stamp)
        report($sformatf("grid_time got %0d want %0d", got.stamp, want.stamp));
      for (c = 0; c < NUM_CH; c++) begin
        if (got.ch[c] !== want.ch[c])
          report($sformatf("grid %0d channel %0d got %h want %h",
                           want.stamp, c, got.ch[c], want.ch[c]));
      end
      if (got.last !== want.last)
        report($sformatf("grid %0d run_last got %b want %b", want.stamp, got.last, want.last));
      if (got.ovf !== want.ovf)
        report($sformatf("grid %0d gap_overflow got %b want %b", want.stamp, got.ovf, want.ovf));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [STEP_W-1:0]    cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // sample_time, pos_x, pos_y, pos_z, angle_roll, angle_pitch, angle_yaw
  logic [TDATA_W-1:0]   s_axis_tdata;
  // restart
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // grid_time, out_x, out_y, out_z, out_roll, out_pitch, out_yaw
  logic [TDATA_W-1:0]   m_axis_tdata;
  // run_last
  logic                 m_axis_tlast;
  // gap_overflow
  logic                 m_axis_tuser;

  int                   send_idle_pct;
  int                   recv_stall_pct;
  pose_grid_tracker     tracker = new();

  uniform_grid_linear_resampler_core #(
    .MAX_RUN    (RUN_LIMIT),
    .VALUE_BITS (32),
    .TIME_BITS  (32)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("** uniform_grid_linear_resampler_core: FAILED **");
    $finish;
  end

  // output back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // collect every output transaction and check it
  always @(posedge clk_i) begin : watch_points
    grid_point_t got;
    int          c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.stamp = m_axis_tdata[DATA_W-1:0];
      for (c = 0; c < NUM_CH; c++) got.ch[c] = m_axis_tdata[DATA_W*(c+1) +: DATA_W];
      got.last = m_axis_tlast;
      got.ovf  = m_axis_tuser;
      tracker.check_point(got);
    end
  end

  function automatic pose_sample_t make_sample(longint unsigned stamp, bit restart,
                                               fill_e fill);
    pose_sample_t s;
    int           c;
    s.stamp   = stamp[DATA_W-1:0];
    s.restart = restart;
    for (c = 0; c < NUM_CH; c++) begin
      case (fill)
        FILL_HIGH: s.ch[c] = 32'h7FFF_FFFF;
        FILL_LOW:  s.ch[c] = 32'h8000_0000;
        FILL_ZERO: s.ch[c] = '0;
        default: begin
          case ($urandom_range(9))
            0:       s.ch[c] = 32'h7FFF_FFFF;
            1:       s.ch[c] = 32'h8000_0000;
            2:       s.ch[c] = '0;
            3:       s.ch[c] = '1;
            default: s.ch[c] = $urandom();
          endcase
        end
      endcase
    end
    return s;
  endfunction

  // one input transaction, with an optional idle gap in front
  task automatic send_sample(pose_sample_t s);
    logic [TDATA_W-1:0] word;
    int                 c;
    int                 gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1500, 1) : $urandom_range(8, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word = '0;
    word[DATA_W-1:0] = s.stamp;
    for (c = 0; c < NUM_CH; c++) word[DATA_W*(c+1) +: DATA_W] = s.ch[c];
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= s.restart;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_sample(s);
  endtask

  // let every due grid point come out, then let the block finish any silent sample
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_grid_step(logic [STEP_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.grid_step = value;
  endtask

  // hand-picked track at the reset grid step of 10000 us
  task automatic run_directed_track();
    pose_sample_t s;
    // first sample after reset without restart: points at 0, 10000, 20000
    send_sample(make_sample(25000, 1'b0, FILL_HIGH));
    // full-scale swing from max to min
    send_sample(make_sample(45000, 1'b0, FILL_LOW));
    // same time, then an earlier time: nothing emitted
    send_sample(make_sample(45000, 1'b0, FILL_RANDOM));
    send_sample(make_sample(30000, 1'b0, FILL_RANDOM));
    // gap that holds no grid point
    send_sample(make_sample(49999, 1'b0, FILL_RANDOM));
    // sample exactly on a grid point
    send_sample(make_sample(50000, 1'b0, FILL_RANDOM));
    // gap too long: run cut at the limit
    send_sample(make_sample(750000, 1'b0, FILL_RANDOM));
    // restarts at the grid origin and just before the next point
    send_sample(make_sample(0, 1'b1, FILL_ZERO));
    send_sample(make_sample(9999, 1'b1, FILL_RANDOM));
    // restart far out: first-sample run cut at the limit
    send_sample(make_sample(1000000, 1'b1, FILL_RANDOM));
    // largest time stamps: later, repeated, restarted, then earlier
    send_sample(make_sample(32'hFFFF_FFFF, 1'b0, FILL_LOW));
    send_sample(make_sample(32'hFFFF_FFFF, 1'b0, FILL_HIGH));
    send_sample(make_sample(32'hFFFF_FFFF, 1'b1, FILL_RANDOM));
    send_sample(make_sample(32'hFFFF_FFFE, 1'b0, FILL_RANDOM));
    // short track with exact and truncated interpolation
    send_sample(make_sample(0, 1'b1, FILL_LOW));
    send_sample(make_sample(10000, 1'b0, FILL_HIGH));
    send_sample(make_sample(15000, 1'b0, FILL_ZERO));
    s = make_sample(20001, 1'b0, FILL_RANDOM);
    s.ch[0] = -32'sd3;
    s.ch[1] = 32'sd3;
    send_sample(s);
  endtask

  // random tracks at one grid step, mostly well-formed with some noise
  task automatic run_phase(logic [STEP_W-1:0] step_val, int idle_pct, int stall_pct,
                           int items);
    longint unsigned span;
    longint unsigned last;
    longint unsigned stamp;
    int unsigned     pick;
    bit              restart;
    drain_and_settle();
    write_grid_step(step_val);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    span = (step_val == '0) ? 1 : step_val;
    last = 64'hFFFF_FFFF;
    repeat (items) begin
      pick    = $urandom_range(99);
      restart = 1'b0;
      if (pick < 8 || last + 4 * span > 64'hFFFF_FFFF) begin
        // new track, now and then far enough out to overflow the run
        restart = 1'b1;
        stamp   = (pick < 2) ? $urandom_range(200 * span) : $urandom_range(3 * span);
      end else if (pick < 82) begin
        stamp = last + $urandom_range(4 * span);
      end else if (pick < 92) begin
        stamp = $urandom_range(last);
      end else begin
        stamp   = $urandom();
        restart = $urandom_range(1);
      end
      send_sample(make_sample(stamp, restart, FILL_RANDOM));
      last = stamp;
    end
  endtask

  // reset, directed track, random phases, final check
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed_track();

    run_phase(20'd1000000, 0, 0, PHASE_ITEMS);
    run_phase(20'd1, 57, 0, PHASE_ITEMS);
    run_phase(20'd0, 0, 57, PHASE_ITEMS);
    run_phase(20'hFFFFF, 36, 36, PHASE_ITEMS);
    run_phase(STEP_W'($urandom_range(5000, 2)), 0, 0, PHASE_ITEMS);
    run_phase(STEP_RESET, 57, 57, PHASE_ITEMS);

    drain_and_settle();
    if (tracker.mismatches == 0) begin
      $display("** uniform_grid_linear_resampler_core: PASSED **");
    end else begin
      $display("** uniform_grid_linear_resampler_core: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/uglr_pkg.sv
rtl/uglr_divider.sv
rtl/uniform_grid_linear_resampler_core.sv
bench/uniform_grid_linear_resampler_core_test.sv
